@@ hdl/teq_pkg.sv @@
// Shared types and codes for the timed event queue.
`timescale 1ns / 1ps
package teq_pkg;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int STEP_W   = 6;
    localparam int IDX_W    = 8;
    localparam int PEND_W   = 9;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 112;

    localparam logic [STEP_W-1:0] RUN_CAP = 6'd63;

    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_PEEK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_LIMIT = 3'd2,
        ST_PAST  = 3'd3,
        ST_FULL  = 3'd4,
        ST_RANGE = 3'd5
    } status_t;

    // Decoded command handed from the front end to the back end
    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   evt_time;
        logic                rel;
        logic [STEP_W-1:0]   steps;
        logic [IDX_W-1:0]    idx;
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   evt_time;
        status_t             status;
        logic [PEND_W-1:0]   pending;
        logic [TIME_W-1:0]   now;
        logic                last;
    } res_t;

endpackage

@@ hdl/teq_front.sv @@
// Front end: accepts input beats, decodes them and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module teq_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // handle[31:0], time[63:32], relative[64], step_count[70:65], peek_index[78:71]
    input  logic [teq_pkg::S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output teq_pkg::cmd_t            cmd
);
    import teq_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       dec;
    logic       push, pop;

    // Decode the beat; a zero step count means the full cap
    always_comb begin
        dec.op       = op_t'(s_tuser);
        dec.handle   = s_tdata[31:0];
        dec.evt_time = s_tdata[63:32];
        dec.rel      = s_tdata[64];
        dec.steps    = (s_tdata[70:65] == '0) ? RUN_CAP : s_tdata[70:65];
        dec.idx      = s_tdata[78:71];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the decoded beat
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ hdl/teq_back.sv @@
// Back end: sorted event store in a ring memory, command sequencer and output register.
`timescale 1ns / 1ps
module teq_back #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [teq_pkg::TIME_W-1:0]  time_limit,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  teq_pkg::cmd_t               cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output teq_pkg::res_t               out_res
);
    import teq_pkg::*;

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int XW  = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS     = 6'b000010,
        S_RUN_RD  = 6'b000100,
        S_RUN_CHK = 6'b001000,
        S_PEEK_RD = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    logic [TIME_W-1:0]   mem_time   [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] mem_handle [QUEUE_DEPTH];

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   when_reg, when_next;
    logic [HANDLE_W-1:0] hdl_reg, hdl_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    res_t                res_reg, res_next;
    res_t                out_reg;
    logic                out_valid_reg;

    logic [AW-1:0]       rd_addr;
    logic [TIME_W-1:0]   rd_time_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [TIME_W-1:0]   wr_time;
    logic [HANDLE_W-1:0] wr_handle;

    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   when_c;
    logic                bad_time;
    logic                can_emit;
    logic                load_out;

    // Map a position in time order to a memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(l);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic res_t mk_res(input logic [HANDLE_W-1:0] h, input logic [TIME_W-1:0] t,
                                    input status_t st, input logic [CW-1:0] pend,
                                    input logic [TIME_W-1:0] nw, input logic lst);
        res_t r;
        r.handle   = h;
        r.evt_time = t;
        r.status   = st;
        r.pending  = PEND_W'(pend);
        r.now      = nw;
        r.last     = lst;
        return r;
    endfunction

    assign can_emit  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Post time check: relative sum carry or absolute time in the past
    always_comb begin
        sum      = {1'b0, now_reg} + {1'b0, cmd.evt_time};
        when_c   = cmd.rel ? sum[TIME_W-1:0] : cmd.evt_time;
        bad_time = cmd.rel ? sum[TIME_W] : (cmd.evt_time < now_reg);
    end

    // Sequence each command
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        now_next   = now_reg;
        when_next  = when_reg;
        hdl_next   = hdl_reg;
        steps_next = steps_reg;
        res_next   = res_reg;
        cmd_ready  = 1'b0;
        load_out   = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_time    = when_reg;
        wr_handle  = hdl_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    ret_next  = S_IDLE;
                    case (cmd.op)
                        OP_POST: begin
                            when_next = when_c;
                            hdl_next  = cmd.handle;
                            if (bad_time) begin
                                res_next   = mk_res('0, '0, ST_PAST, cnt_reg, now_reg, 1'b1);
                                state_next = S_EMIT;
                            end else if (cnt_reg == CW'(QUEUE_DEPTH)) begin
                                res_next   = mk_res('0, '0, ST_FULL, cnt_reg, now_reg, 1'b1);
                                state_next = S_EMIT;
                            end else if (cnt_reg == '0) begin
                                wr_en      = 1'b1;
                                wr_addr    = head_reg;
                                wr_time    = when_c;
                                wr_handle  = cmd.handle;
                                cnt_next   = cnt_reg + CW'(1);
                                res_next   = mk_res('0, '0, ST_OK, cnt_next, now_reg, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                pos_next   = cnt_reg;
                                rd_addr    = phys(head_reg, cnt_reg - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        OP_RUN: begin
                            steps_next = cmd.steps;
                            state_next = S_RUN_RD;
                        end
                        OP_CLEAR: begin
                            cnt_next   = '0;
                            res_next   = mk_res('0, '0, ST_OK, '0, now_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                        OP_PEEK: begin
                            if (XW'(cmd.idx) >= XW'(cnt_reg)) begin
                                res_next   = mk_res('0, '0, ST_RANGE, cnt_reg, now_reg, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                rd_addr    = phys(head_reg, CW'(cmd.idx));
                                state_next = S_PEEK_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Shift later entries up one slot per cycle, then drop the new event in
            S_INS: begin
                if (pos_reg != '0 && rd_time_reg > when_reg) begin
                    wr_en     = 1'b1;
                    wr_addr   = phys(head_reg, pos_reg);
                    wr_time   = rd_time_reg;
                    wr_handle = rd_handle_reg;
                    pos_next  = pos_reg - CW'(1);
                    rd_addr   = phys(head_reg, pos_reg - CW'(2));
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = phys(head_reg, pos_reg);
                    cnt_next   = cnt_reg + CW'(1);
                    res_next   = mk_res('0, '0, ST_OK, cnt_next, now_reg, 1'b1);
                    state_next = S_EMIT;
                end
            end

            S_RUN_RD: begin
                ret_next = S_IDLE;
                if (cnt_reg == '0) begin
                    res_next   = mk_res('0, '0, ST_EMPTY, cnt_reg, now_reg, 1'b1);
                    state_next = S_EMIT;
                end else begin
                    rd_addr    = head_reg;
                    state_next = S_RUN_CHK;
                end
            end

            // Head time becomes current time; stop at the limit, else pop
            S_RUN_CHK: begin
                now_next = rd_time_reg;
                if (time_limit != '0 && rd_time_reg >= time_limit) begin
                    res_next = mk_res('0, '0, ST_LIMIT, cnt_reg, rd_time_reg, 1'b1);
                    ret_next = S_IDLE;
                end else begin
                    head_next  = phys(head_reg, CW'(1));
                    cnt_next   = cnt_reg - CW'(1);
                    steps_next = steps_reg - STEP_W'(1);
                    res_next   = mk_res(rd_handle_reg, rd_time_reg, ST_OK, cnt_next,
                                        rd_time_reg, steps_reg == STEP_W'(1));
                    ret_next   = (steps_reg == STEP_W'(1)) ? S_IDLE : S_RUN_RD;
                end
                state_next = S_EMIT;
            end

            S_PEEK_RD: begin
                res_next   = mk_res(rd_handle_reg, rd_time_reg, ST_OK, cnt_reg, now_reg, 1'b1);
                state_next = S_EMIT;
            end

            S_EMIT: begin
                if (can_emit) begin
                    load_out   = 1'b1;
                    state_next = ret_reg;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            now_reg   <= now_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        when_reg  <= when_next;
        hdl_reg   <= hdl_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

    // Event store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_time[wr_addr]   <= wr_time;
            mem_handle[wr_addr] <= wr_handle;
        end
        rd_time_reg   <= mem_time[rd_addr];
        rd_handle_reg <= mem_handle[rd_addr];
    end

endmodule

@@ hdl/timed_event_queue.sv @@
// A post shifts each later-timed entry up one slot before the new event is written;
// a post into an empty store or a refused post, a clear and an out-of-range peek go
// straight to the output load. Run: each popped event goes through head read, check
// and output load; the single-read ring memory of the event store sets this order.
// Reset (aresetn low, synchronous) empties the queue, zeroes current time and the limit;
// the store memory is not cleared. The front queue holds two commands while the back works.
`timescale 1ns / 1ps
module timed_event_queue #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // event_handle[31:0], event_time[63:32], time_is_relative[64],
    // step_count[70:65], peek_index[78:71], zero fill[79]
    input  logic [teq_pkg::S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_handle[31:0], out_time[63:32], pending_count[72:64],
    // current_time[104:73], zero fill[111:105]
    output logic [teq_pkg::M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]                   m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import teq_pkg::*;

    logic              cmd_valid, cmd_ready;
    cmd_t              cmd;
    res_t              res;
    logic [TIME_W-1:0] time_limit_reg;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? time_limit_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_limit_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            time_limit_reg <= pwdata;
        end
    end

    teq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    teq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .time_limit (time_limit_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    // Pack the result beat
    assign m_tdata = {7'd0, res.now, res.pending, res.evt_time, res.handle};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

@@ hdl/teq_checker.sv @@
// Port-level checks for the timed event queue, bound to the top level.
`timescale 1ns / 1ps
module teq_port_checks #(
    parameter int QUEUE_DEPTH = 256
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);
    import teq_pkg::*;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Only defined status codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_RANGE)
        else $error("undefined status code");

    // Pending count never exceeds the store depth
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[72:64]) <= 32'(QUEUE_DEPTH))
        else $error("pending count beyond depth");

    // Every non-ok result closes its command
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast)
        else $error("error result without last");

    // Error results carry no event
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == '0)
        else $error("error result carries event data");

endmodule

bind timed_event_queue teq_port_checks #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_teq_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/teq_checker.sv @@
// Scoreboard for the timed event queue: predicts result beats and compares them.
`timescale 1ns / 1ps
module teq_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [teq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [teq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [2:0]                   m_tuser,
    input  logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output int                           fail_count,
    output int                           pending_beats,
    output int                           beats_seen
);
    import teq_pkg::*;

    localparam int DEPTH = 256;

    logic [TIME_W-1:0]   ev_time [DEPTH];
    logic [HANDLE_W-1:0] ev_hdl [DEPTH];
    int                  ev_cnt;
    logic [TIME_W-1:0]   now_t;
    logic [TIME_W-1:0]   limit_t;
    res_t                want_q[$];

    assign pending_beats = want_q.size();

    function automatic res_t mk(logic [31:0] h, logic [31:0] t, status_t st, logic l);
        res_t r;
        r.handle = h; r.evt_time = t; r.status = st;
        r.pending = PEND_W'(ev_cnt); r.now = now_t; r.last = l;
        return r;
    endfunction

    // Advance the predicted queue by one command beat
    task automatic schedule_cmd(op_t op, logic [79:0] d);
        logic [31:0] h, t;
        logic [32:0] sum;
        logic        rel;
        int          steps, pos, idx;
        h = d[31:0]; t = d[63:32]; rel = d[64];
        steps = int'(d[70:65]); idx = int'(d[78:71]);
        case (op)
            OP_POST: begin
                sum = {1'b0, t};
                if (rel) sum = {1'b0, now_t} + {1'b0, t};
                if (sum[32] || sum[31:0] < now_t) want_q.push_back(mk('0, '0, ST_PAST, 1'b1));
                else if (ev_cnt >= DEPTH) want_q.push_back(mk('0, '0, ST_FULL, 1'b1));
                else begin
                    pos = ev_cnt;
                    while (pos > 0 && ev_time[pos-1] > sum[31:0]) begin
                        ev_time[pos] = ev_time[pos-1];
                        ev_hdl[pos] = ev_hdl[pos-1];
                        pos--;
                    end
                    ev_time[pos] = sum[31:0];
                    ev_hdl[pos] = h;
                    ev_cnt++;
                    want_q.push_back(mk('0, '0, ST_OK, 1'b1));
                end
            end
            OP_RUN: begin
                if (steps == 0) steps = int'(RUN_CAP);
                while (steps > 0) begin
                    if (ev_cnt == 0) begin
                        want_q.push_back(mk('0, '0, ST_EMPTY, 1'b1));
                        break;
                    end
                    now_t = ev_time[0];
                    if (limit_t != 0 && now_t >= limit_t) begin
                        want_q.push_back(mk('0, '0, ST_LIMIT, 1'b1));
                        break;
                    end
                    h = ev_hdl[0]; t = ev_time[0];
                    ev_cnt--;
                    for (int i = 0; i < ev_cnt; i++) begin
                        ev_time[i] = ev_time[i+1];
                        ev_hdl[i] = ev_hdl[i+1];
                    end
                    steps--;
                    want_q.push_back(mk(h, t, ST_OK, steps == 0));
                end
            end
            OP_CLEAR: begin
                ev_cnt = 0;
                want_q.push_back(mk('0, '0, ST_OK, 1'b1));
            end
            default: begin
                if (idx >= ev_cnt) want_q.push_back(mk('0, '0, ST_RANGE, 1'b1));
                else want_q.push_back(mk(ev_hdl[idx], ev_time[idx], ST_OK, 1'b1));
            end
        endcase
    endtask

    // Compare one observed beat with the oldest prediction
    task automatic check_beat();
        res_t w;
        if (want_q.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
            return;
        end
        w = want_q.pop_front();
        if (m_tdata[31:0] !== w.handle) begin
            $error("out_handle exp %0h got %0h", w.handle, m_tdata[31:0]); fail_count++;
        end
        if (m_tdata[63:32] !== w.evt_time) begin
            $error("out_time exp %0h got %0h", w.evt_time, m_tdata[63:32]); fail_count++;
        end
        if (m_tuser !== w.status) begin
            $error("status exp %0d got %0d", w.status, m_tuser); fail_count++;
        end
        if (m_tdata[72:64] !== w.pending) begin
            $error("pending_count exp %0d got %0d", w.pending, m_tdata[72:64]); fail_count++;
        end
        if (m_tdata[104:73] !== w.now) begin
            $error("current_time exp %0h got %0h", w.now, m_tdata[104:73]); fail_count++;
        end
        if (m_tlast !== w.last) begin
            $error("last exp %0d got %0d", w.last, m_tlast); fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ev_cnt = 0;
            now_t = '0;
            limit_t = '0;
            fail_count = 0;
            beats_seen = 0;
        end else begin
            if (psel && penable && pwrite && paddr == 3'd0) limit_t = pwdata;
            if (s_tvalid && s_tready) schedule_cmd(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                check_beat();
                beats_seen++;
            end
        end
    end
endmodule

@@ test/tb_timed_event_queue.sv @@
// Stimulus and verdict for the timed event queue.
`timescale 1ns / 1ps
module tb_timed_event_queue;
    import teq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    // event_handle, event_time, time_is_relative, step_count, peek_index, fill
    logic [S_DATA_W-1:0] s_tdata = '0;
    // operation
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    // out_handle, out_time, pending_count, current_time, fill
    logic [M_DATA_W-1:0] m_tdata;
    // status
    logic [2:0]          m_tuser;
    logic                m_tlast;
    logic                psel = 0, penable = 0, pwrite = 0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count, pending_beats, beats_seen;
    logic                calm = 0;
    int                  idle_run = 0;
    int                  cmd_cnt = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    timed_event_queue uut (.*);
    teq_checker chk (.*);

    // Stall the result side in random bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                m_tready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("timed_event_queue verification failed");
            $finish;
        end
    end

    // Drive one beat; valid stays up into the next beat unless an idle burst comes first
    task automatic send_cmd(op_t op, logic [31:0] h, logic [31:0] t, logic rel,
                            logic [5:0] st, logic [7:0] idx);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {1'b0, idx, st, rel, t, h};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmd_cnt++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_beats != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_limit(logic [31:0] v);
        drain();
        psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // Mostly posts near current time, runs, sometimes peeks and clears
    task automatic random_cmd();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            send_cmd(OP_POST, $urandom, ($urandom_range(0, 9) == 0) ? $urandom
                     : $urandom_range(0, 300), $urandom_range(0, 1) ? 1'b1 : 1'b0,
                     6'($urandom), 8'($urandom));
        else if (k < 72)
            send_cmd(OP_RUN, $urandom, $urandom, 1'($urandom),
                     $urandom_range(0, 9) == 0 ? 6'd0 : 6'($urandom_range(1, 6)), 8'($urandom));
        else if (k < 96)
            send_cmd(OP_PEEK, $urandom, $urandom, 1'($urandom), 6'($urandom),
                     $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom));
        else
            send_cmd(OP_CLEAR, $urandom, $urandom, 1'($urandom), 6'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty run, range peek, equal-time order, past and overflow
        send_cmd(OP_RUN, 0, 0, 0, 6'd1, 0);
        send_cmd(OP_PEEK, 0, 0, 0, 0, 8'd0);
        send_cmd(OP_POST, 32'hFFFFFFFF, 32'd100, 0, 0, 0);
        send_cmd(OP_POST, 32'h1, 32'd100, 0, 0, 0);
        send_cmd(OP_POST, 32'h2, 32'd50, 1, 0, 0);
        send_cmd(OP_POST, 32'h3, 32'hFFFFFFFF, 0, 0, 0);
        send_cmd(OP_PEEK, 0, 0, 0, 0, 8'd1);
        send_cmd(OP_PEEK, 0, 0, 0, 0, 8'd255);
        send_cmd(OP_RUN, 0, 0, 0, 6'd2, 0);
        send_cmd(OP_POST, 32'h4, 32'd10, 0, 0, 0);
        send_cmd(OP_POST, 32'h5, 32'hFFFFFFFF, 1, 0, 0);
        send_cmd(OP_RUN, 0, 0, 0, 6'd63, 0);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
        set_limit(32'hFFFFFFFF);
        send_cmd(OP_POST, 32'h6, 32'hFFFFFFFF, 0, 0, 0);
        send_cmd(OP_RUN, 0, 0, 0, 6'd0, 0);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
        set_limit(32'd0);

        // Fill the store to the brim and overflow it
        for (int i = 0; i < 257; i++)
            send_cmd(OP_POST, $urandom, 32'hFFFFFFFF, 0, 0, 0);
        send_cmd(OP_PEEK, 0, 0, 0, 0, 8'd255);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
        send_cmd(OP_RUN, 0, 0, 0, 6'd5, 0);

        // Random phases under varying limits; last phase without idling
        for (int ph = 0; ph < 4; ph++) begin
            set_limit(ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFFFFFF : $urandom_range(200, 5000));
            send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
            if (ph == 3) calm = 1;
            for (int i = 0; i < 50; i++) random_cmd();
        end

        drain();
        $display("Covered %0d commands producing %0d result beats", cmd_cnt, beats_seen);
        $display("including full store, limit stops, past/overflow posts and peeks");
        if (fail_count == 0) $display("timed_event_queue verification clean");
        else $display("timed_event_queue verification failed");
        $finish;
    end
endmodule
